### hdl/timed_hysteresis_zone_detector_top_macros.svh
// ----------------------------------------------------------------------------
// Timed hysteresis zone detector assertion macros
// Shared assertion forms, clocked on i_clk and quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_HYSTERESIS_ZONE_DETECTOR_TOP_MACROS_SVH
`define TIMED_HYSTERESIS_ZONE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication.
`define TDZ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TDZ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tdz_pkg.sv
// ----------------------------------------------------------------------------
// Timed hysteresis zone detector package
// Shared widths, codes and types for the zone detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tdz_pkg;

    localparam int NZONES_DEF      = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ZONE_W     = 2;
    localparam int USE_W      = 3;
    localparam int LEVEL_W    = 16;
    localparam int ELAPSED_W  = 15;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 63;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_UNINIT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT_ENTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT_LEAVE = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ZONES_IN_USE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_BASE    = 4'd1;

    // Packs to the 63-bit zone word layout.
    typedef struct packed {
        logic                 above;
        logic [ELAPSED_W-1:0] exit_ms;
        logic [ELAPSED_W-1:0] enter_ms;
        logic [LEVEL_W-1:0]   exit_lv;
        logic [LEVEL_W-1:0]   enter_lv;
    } t_zone_cfg;

    // Head of the item queue as seen by the back end.
    typedef struct packed {
        logic valid;
        logic kind;
    } t_q_status;

endpackage

`default_nettype wire

### hdl/tdz_front.sv
// ----------------------------------------------------------------------------
// Zone detector front end
// Accepts input beats, tags them as tick or sample and queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tdz_front #(
    parameter int SAMPLE_BITS = tdz_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_kind,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output tdz_pkg::t_q_status                 o_q,
    output logic signed [SAMPLE_BITS-1:0]      o_q_sample,
    input  wire logic                          i_q_pop
);

    logic                          r_kind [2];
    logic signed [SAMPLE_BITS-1:0] r_smp  [2];
    logic                          r_head;
    logic [1:0]                    r_cnt;
    logic                          n_head;
    logic [1:0]                    n_cnt;
    logic                          push;
    logic                          pop;
    logic                          tail;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign pop     = o_q.valid && i_q_pop;
    assign tail    = r_head ^ r_cnt[0];

    assign o_q.valid  = (r_cnt != 2'd0);
    assign o_q.kind   = r_kind[r_head];
    assign o_q_sample = r_smp[r_head];

    always_comb begin
        n_head = pop ? ~r_head : r_head;
        n_cnt  = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[tail] <= (i_kind == tdz_pkg::KIND_TICK) ? tdz_pkg::KIND_TICK
                                                          : tdz_pkg::KIND_SAMPLE;
            r_smp[tail]  <= i_sample;
        end
    end

endmodule

`default_nettype wire

### hdl/tdz_back.sv
// ----------------------------------------------------------------------------
// Zone detector back end
// Applies ticks to all elapsed counters and scans the zones in use one per
// cycle on a sample unless an event is held up by an output stall, emitting
// enter and leave events through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_hysteresis_zone_detector_top_macros.svh"

module tdz_back #(
    parameter int NZONES      = tdz_pkg::NZONES_DEF,
    parameter int SAMPLE_BITS = tdz_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tdz_pkg::t_q_status            i_q,
    input  wire logic signed [SAMPLE_BITS-1:0] i_q_sample,
    output logic                               o_q_pop,
    input  wire logic [tdz_pkg::USE_W-1:0]     i_zones_in_use,
    input  wire tdz_pkg::t_zone_cfg            i_zone_cfg [NZONES],
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [tdz_pkg::ZONE_W-1:0]         o_zone,
    output logic                               o_entered,
    output logic                               o_last
);

    localparam int IDX_W = (NZONES > 1) ? $clog2(NZONES) : 1;
    localparam int CNT_W = $clog2(NZONES + 1);
    localparam int CMP_W = (SAMPLE_BITS > tdz_pkg::LEVEL_W) ? SAMPLE_BITS
                                                            : tdz_pkg::LEVEL_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                         r_state;
    logic signed [SAMPLE_BITS-1:0]      r_sample;
    logic [CNT_W-1:0]                   r_idx;
    logic [CNT_W-1:0]                   r_count;
    logic [tdz_pkg::MODE_W-1:0]         r_mode    [NZONES];
    logic [tdz_pkg::ELAPSED_W-1:0]      r_elapsed [NZONES];
    logic                               r_pend_valid;
    logic [IDX_W-1:0]                   r_pend_zone;
    logic                               r_pend_entered;
    logic                               r_out_valid;
    logic [tdz_pkg::ZONE_W-1:0]         r_out_zone;
    logic                               r_out_entered;
    logic                               r_out_last;

    logic [IDX_W-1:0]                   idx;
    tdz_pkg::t_zone_cfg                 cfg;
    logic [tdz_pkg::MODE_W-1:0]         cur_mode;
    logic [tdz_pkg::ELAPSED_W-1:0]      cur_el;
    logic [tdz_pkg::MODE_W-1:0]         eff_mode;
    logic [tdz_pkg::ELAPSED_W-1:0]      eff_el;
    logic signed [CMP_W-1:0]            s_x;
    logic signed [CMP_W-1:0]            enter_x;
    logic signed [CMP_W-1:0]            exit_x;
    logic                               active;
    logic                               holds;
    logic [tdz_pkg::ELAPSED_W-1:0]      limit;
    logic [tdz_pkg::MODE_W-1:0]         next_mode;
    logic                               ev;
    logic [tdz_pkg::MODE_W-1:0]         new_mode;
    logic [tdz_pkg::ELAPSED_W-1:0]      new_el;
    logic                               out_free;
    logic                               scan_go;
    logic                               scan_last;
    logic                               flush_go;
    logic                               push;
    logic                               push_last;
    logic [CNT_W-1:0]                   use_cnt;

    assign idx      = r_idx[IDX_W-1:0];
    assign cfg      = i_zone_cfg[idx];
    assign cur_mode = r_mode[idx];
    assign cur_el   = r_elapsed[idx];

    // A zone's first sample starts it as waiting to enter with a clear counter.
    assign eff_mode = (cur_mode == tdz_pkg::MODE_UNINIT) ? tdz_pkg::MODE_WAIT_ENTER : cur_mode;
    assign eff_el   = (cur_mode == tdz_pkg::MODE_UNINIT) ? '0 : cur_el;

    assign s_x     = CMP_W'(r_sample);
    assign enter_x = CMP_W'(signed'(cfg.enter_lv));
    assign exit_x  = CMP_W'(signed'(cfg.exit_lv));

    always_comb begin
        case (eff_mode)
            tdz_pkg::MODE_WAIT_ENTER: begin
                active    = 1'b1;
                holds     = cfg.above ? (s_x >= enter_x) : (s_x <= enter_x);
                limit     = cfg.enter_ms;
                next_mode = tdz_pkg::MODE_WAIT_LEAVE;
            end
            tdz_pkg::MODE_WAIT_LEAVE: begin
                active    = 1'b1;
                holds     = cfg.above ? (s_x <= exit_x) : (s_x >= exit_x);
                limit     = cfg.exit_ms;
                next_mode = tdz_pkg::MODE_WAIT_ENTER;
            end
            default: begin
                active    = 1'b0;
                holds     = 1'b0;
                limit     = '0;
                next_mode = eff_mode;
            end
        endcase
    end

    assign ev       = active && holds && (eff_el >= limit);
    assign new_mode = !active ? cur_mode : (ev ? next_mode : eff_mode);
    assign new_el   = !active ? cur_el : ((!holds || ev) ? '0 : eff_el);

    assign out_free  = !r_out_valid || !i_stall;
    assign scan_go   = (r_state == ST_SCAN) && (!(ev && r_pend_valid) || out_free);
    assign scan_last = ((r_idx + CNT_W'(1)) == r_count);
    assign flush_go  = (r_state == ST_FLUSH) && (!r_pend_valid || out_free);

    // An event goes out once the next one is known, so its last flag is settled.
    assign push      = (scan_go && ev && r_pend_valid) || (flush_go && r_pend_valid);
    assign push_last = (r_state == ST_FLUSH);

    assign use_cnt = ({1'b0, i_zones_in_use} > (tdz_pkg::USE_W + 1)'(NZONES))
                     ? CNT_W'(NZONES) : CNT_W'(i_zones_in_use);

    assign o_q_pop   = (r_state == ST_IDLE) && i_q.valid;
    assign o_valid   = r_out_valid;
    assign o_zone    = r_out_zone;
    assign o_entered = r_out_entered;
    assign o_last    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int z = 0; z < NZONES; z++) begin
                r_mode[z]    <= tdz_pkg::MODE_UNINIT;
                r_elapsed[z] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q.valid) begin
                        if (i_q.kind == tdz_pkg::KIND_TICK) begin
                            for (int z = 0; z < NZONES; z++) begin
                                if (r_elapsed[z] != tdz_pkg::ELAPSED_MAX) begin
                                    r_elapsed[z] <= r_elapsed[z] + 1'b1;
                                end
                            end
                        end else begin
                            r_idx   <= '0;
                            r_count <= use_cnt;
                            r_state <= (use_cnt == '0) ? ST_IDLE : ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_go) begin
                        r_mode[idx]    <= new_mode;
                        r_elapsed[idx] <= new_el;
                        if (ev) begin
                            r_pend_valid <= 1'b1;
                        end
                        r_idx <= r_idx + CNT_W'(1);
                        if (scan_last) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (flush_go) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q.kind == tdz_pkg::KIND_SAMPLE) begin
            r_sample <= i_q_sample;
        end
        if (scan_go && ev) begin
            r_pend_zone    <= idx;
            r_pend_entered <= (next_mode == tdz_pkg::MODE_WAIT_LEAVE);
        end
        if (push) begin
            r_out_zone    <= tdz_pkg::ZONE_W'(r_pend_zone);
            r_out_entered <= r_pend_entered;
            r_out_last    <= push_last;
        end
    end

    `TDZ_ASSERT_IMP(a_idle_no_pend, r_state == ST_IDLE, !r_pend_valid,
        "pending event left behind at end of sample")
    `TDZ_ASSERT_IMP(a_scan_in_range, r_state == ST_SCAN, r_idx < r_count,
        "zone scan index past zones in use")
    `TDZ_ASSERT_NXT(a_blocked_holds,
        r_state == ST_SCAN && ev && r_pend_valid && !out_free,
        r_state == ST_SCAN && $stable(r_idx),
        "zone scan advanced while its event could not be placed")

endmodule

`default_nettype wire

### hdl/timed_hysteresis_zone_detector_top.sv
// Throughput: the back end scans one zone per cycle while output stalls do not
//   hold it, and takes no new beat from the queue until a sample's scan is done.
// Reset: synchronous, active low; clears the queue, all zones to uninitialised
//   with zero elapsed time, and the configuration registers to zero.
// ----------------------------------------------------------------------------
// Timed hysteresis zone detector
// Per-zone hysteresis thresholds with millisecond confirmation times over one
// shared sample stream; zone side changes come out as event beats.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_hysteresis_zone_detector_top #(
    parameter int NZONES      = tdz_pkg::NZONES_DEF,
    parameter int SAMPLE_BITS = tdz_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_kind,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [tdz_pkg::ZONE_W-1:0]               o_zone,
    output logic                                     o_entered,
    output logic                                     o_last,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [tdz_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [tdz_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [tdz_pkg::USE_W-1:0]     r_zones_in_use;
    tdz_pkg::t_zone_cfg            r_zone_cfg [NZONES];

    tdz_pkg::t_q_status            q;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic                          q_pop;
    logic                          cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Writes to indexes beyond the zone table drop silently.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zones_in_use <= '0;
            for (int z = 0; z < NZONES; z++) begin
                r_zone_cfg[z] <= '0;
            end
        end else if (cfg_we) begin
            if (i_cfg_index == tdz_pkg::REG_ZONES_IN_USE) begin
                r_zones_in_use <= i_cfg_data[tdz_pkg::USE_W-1:0];
            end
            for (int z = 0; z < NZONES; z++) begin
                if (i_cfg_index == tdz_pkg::REG_ZONE_BASE + tdz_pkg::CFG_IDX_W'(z)) begin
                    r_zone_cfg[z] <= i_cfg_data;
                end
            end
        end
    end

    tdz_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_sample   (i_sample),
        .o_q        (q),
        .o_q_sample (q_sample),
        .i_q_pop    (q_pop)
    );

    tdz_back #(
        .NZONES      (NZONES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (q),
        .i_q_sample     (q_sample),
        .o_q_pop        (q_pop),
        .i_zones_in_use (r_zones_in_use),
        .i_zone_cfg     (r_zone_cfg),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_zone         (o_zone),
        .o_entered      (o_entered),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
